### rtl/gfmi_pkg.sv
// Shared types, constants and helper functions for the GF(2^8) multiply and inverse block.
// Used by gfmi_mul, gfmi_datapath, gfmi_ctrl and gf256_multiply_inverse.
// Depends on nothing.
package gfmi_pkg;

    localparam int unsigned C_ELEM_W   = 8;
    localparam int unsigned C_POLY_W   = C_ELEM_W + 1;
    localparam int unsigned C_CLMUL_W  = 2 * C_ELEM_W - 1;
    localparam int unsigned C_DEG_W    = 4;
    localparam int unsigned C_APB_AW   = 3;
    localparam int unsigned C_APB_DW   = 32;

    // Register map (word index taken from paddr[2])
    localparam logic C_REG_MODULUS = 1'b0;

    localparam logic [C_POLY_W-1:0] C_MODULUS_RESET = 9'h11B;

    // Degree of a polynomial: index of its highest set bit, zero for zero
    function automatic logic [C_DEG_W-1:0] f_poly_degree(input logic [C_POLY_W-1:0] p);
        logic [C_DEG_W-1:0] d;
        d = '0;
        for (int k = 0; k < int'(C_POLY_W); k++) begin
            if (p[k]) begin
                d = C_DEG_W'(k);
            end
        end
        return d;
    endfunction

    localparam logic [C_DEG_W-1:0] C_DEG_RESET = f_poly_degree(C_MODULUS_RESET);

    // Reduction polynomial as seen by the multiplier
    typedef struct packed {
        logic [C_POLY_W-1:0] poly;
        logic [C_DEG_W-1:0]  deg;
        logic                nz;
    } t_poly_cfg;

    // Sideband carried alongside each multiplication
    typedef struct packed {
        logic                vld;
        logic                is_prod;
        logic [C_ELEM_W-1:0] cand;
    } t_mul_tag;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic issue;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_issue;
        logic hit;
        logic pipe_empty;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

### rtl/gfmi_mul.sv
// Three-stage pipelined GF(2^8) multiplier: carry-less product, then reduction
// of the upper and lower bit ranges in two registered steps. Depends on gfmi_pkg.
module gfmi_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfmi_pkg::t_poly_cfg           i_cfg,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_x,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_y,
    input  gfmi_pkg::t_mul_tag            i_tag,
    output logic [gfmi_pkg::C_ELEM_W-1:0] o_res,
    output gfmi_pkg::t_mul_tag            o_tag,
    output logic                          o_empty
);
    import gfmi_pkg::*;

    logic [C_CLMUL_W-1:0] n_p1, n_p2, n_p3;
    logic [C_CLMUL_W-1:0] r_p1, r_p2, r_p3;
    t_mul_tag             r_tag1, r_tag2, r_tag3;
    logic [C_CLMUL_W-1:0] w_mpoly;

    assign w_mpoly = C_CLMUL_W'(i_cfg.poly);

    // Carry-less product of the two bytes
    always_comb begin
        n_p1 = '0;
        for (int k = 0; k < int'(C_ELEM_W); k++) begin
            if (i_y[k]) begin
                n_p1 = n_p1 ^ (C_CLMUL_W'(i_x) << k);
            end
        end
    end

    // Reduce bits 14..8 (only those at or above the polynomial degree)
    always_comb begin
        n_p2 = r_p1;
        for (int k = int'(C_CLMUL_W) - 1; k >= int'(C_ELEM_W); k--) begin
            if (i_cfg.nz && (C_DEG_W'(k) >= i_cfg.deg) && n_p2[k]) begin
                n_p2 = n_p2 ^ (w_mpoly << (C_DEG_W'(k) - i_cfg.deg));
            end
        end
    end

    // Reduce bits 7..0; a constant-one polynomial clears everything here
    always_comb begin
        n_p3 = r_p2;
        for (int k = int'(C_ELEM_W) - 1; k >= 0; k--) begin
            if (i_cfg.nz && (C_DEG_W'(k) >= i_cfg.deg) && n_p3[k]) begin
                n_p3 = n_p3 ^ (w_mpoly << (C_DEG_W'(k) - i_cfg.deg));
            end
        end
    end

    // Stage payloads and valids
    always_ff @(posedge i_clk) begin
        r_p1           <= n_p1;
        r_p2           <= n_p2;
        r_p3           <= n_p3;
        r_tag1.is_prod <= i_tag.is_prod;
        r_tag1.cand    <= i_tag.cand;
        r_tag2.is_prod <= r_tag1.is_prod;
        r_tag2.cand    <= r_tag1.cand;
        r_tag3.is_prod <= r_tag2.is_prod;
        r_tag3.cand    <= r_tag2.cand;
        if (!i_rst_n) begin
            r_tag1.vld <= 1'b0;
            r_tag2.vld <= 1'b0;
            r_tag3.vld <= 1'b0;
        end else begin
            r_tag1.vld <= i_tag.vld;
            r_tag2.vld <= r_tag1.vld;
            r_tag3.vld <= r_tag2.vld;
        end
    end

    assign o_res   = r_p3[C_ELEM_W-1:0];
    assign o_tag   = r_tag3;
    assign o_empty = !(r_tag1.vld || r_tag2.vld || r_tag3.vld);

endmodule

### rtl/gfmi_datapath.sv
// Datapath: operand registers, candidate counter, shared multiplier and result
// registers. Depends on gfmi_pkg and gfmi_mul.
module gfmi_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfmi_pkg::t_poly_cfg           i_cfg,
    input  gfmi_pkg::t_dp_cmd             i_cmd,
    output gfmi_pkg::t_dp_sts             o_sts,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_operand_a,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_operand_b,
    output logic [gfmi_pkg::C_ELEM_W-1:0] o_product,
    output logic [gfmi_pkg::C_ELEM_W-1:0] o_inverse,
    output logic                          o_has_inverse
);
    import gfmi_pkg::*;

    logic [C_ELEM_W-1:0] r_a, r_b;
    logic [C_ELEM_W-1:0] r_cand;
    logic [C_ELEM_W-1:0] r_product, r_inverse;
    logic                r_found;
    logic [C_ELEM_W-1:0] w_y;
    t_mul_tag            w_in_tag;
    t_mul_tag            w_out_tag;
    logic [C_ELEM_W-1:0] w_res;
    logic                w_empty;
    logic                w_hit;

    // Counter value zero issues the product; then candidates 255 down to 1
    assign w_in_tag.vld     = i_cmd.issue;
    assign w_in_tag.is_prod = (r_cand == '0);
    assign w_in_tag.cand    = r_cand;
    assign w_y              = w_in_tag.is_prod ? r_b : r_cand;

    gfmi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_x     (r_a),
        .i_y     (w_y),
        .i_tag   (w_in_tag),
        .o_res   (w_res),
        .o_tag   (w_out_tag),
        .o_empty (w_empty)
    );

    // First candidate giving one is the largest
    assign w_hit = w_out_tag.vld && !w_out_tag.is_prod && (w_res == C_ELEM_W'(1)) && !r_found;

    // Operands and candidate counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
            r_cand <= '0;
        end else if (i_cmd.issue) begin
            r_cand <= r_cand - C_ELEM_W'(1);
        end
    end

    // Results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (w_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_inverse <= '0;
        end else if (w_hit) begin
            r_inverse <= w_out_tag.cand;
        end
        if (w_out_tag.vld && w_out_tag.is_prod) begin
            r_product <= w_res;
        end
    end

    assign o_sts.last_issue = (r_cand == C_ELEM_W'(1));
    assign o_sts.hit        = w_hit;
    assign o_sts.pipe_empty = w_empty;

    assign o_product     = r_product;
    assign o_inverse     = r_inverse;
    assign o_has_inverse = r_found;

endmodule

### rtl/gfmi_ctrl.sv
// Controller state machine: loads an item, issues multiplications, waits for
// the pipeline to drain and strobes the result. Depends on gfmi_pkg.
module gfmi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gfmi_pkg::t_dp_sts i_sts,
    output gfmi_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import gfmi_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.issue = 1'b0;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_sts.hit || i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/gf256_multiply_inverse.sv
// Top level of the GF(2^8) multiply and inverse block: APB register for the
// reduction polynomial, controller and datapath. Depends on gfmi_pkg, gfmi_ctrl, gfmi_datapath.
//
//   channel  | signals                                        | transfer when
//   ---------+------------------------------------------------+----------------------------
//   item in  | i_operand_a, i_operand_b                       | start high, busy low
//   result   | o_product, o_inverse, o_has_inverse            | o_done high (one cycle)
//   config   | psel, penable, pwrite, paddr, pwdata, prdata   | psel & penable & pwrite
//
// For each item, from start to the o_done cycle, the shared three-stage field
// multiplier takes the product, then candidates 255 down to 1, one per cycle,
// and stops at the first that gives one, then drains the pipeline.
// Reset (synchronous, active low) sets the polynomial to 0x11B and idles the block.
// The receiver cannot stall: the result is valid from the o_done cycle until the next start is taken.
module gf256_multiply_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_operand_a,
    input  logic [gfmi_pkg::C_ELEM_W-1:0] i_operand_b,
    output logic                          o_done,
    output logic [gfmi_pkg::C_ELEM_W-1:0] o_product,
    output logic [gfmi_pkg::C_ELEM_W-1:0] o_inverse,
    output logic                          o_has_inverse,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gfmi_pkg::C_APB_AW-1:0] paddr,
    input  logic [gfmi_pkg::C_APB_DW-1:0] pwdata,
    output logic [gfmi_pkg::C_APB_DW-1:0] prdata,
    output logic                          pready
);
    import gfmi_pkg::*;

    logic [C_POLY_W-1:0] r_modulus;
    logic [C_DEG_W-1:0]  r_deg;
    logic                w_wr;
    t_poly_cfg           w_cfg;
    t_dp_cmd             w_cmd;
    t_dp_sts             w_sts;

    // APB register access
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == C_REG_MODULUS);
    assign prdata = (paddr[2] == C_REG_MODULUS) ? C_APB_DW'(r_modulus) : '0;

    // Polynomial and its degree, kept together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= C_MODULUS_RESET;
            r_deg     <= C_DEG_RESET;
        end else if (w_wr) begin
            r_modulus <= pwdata[C_POLY_W-1:0];
            r_deg     <= f_poly_degree(pwdata[C_POLY_W-1:0]);
        end
    end

    assign w_cfg.poly = r_modulus;
    assign w_cfg.deg  = r_deg;
    assign w_cfg.nz   = (r_modulus != '0);

    gfmi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    gfmi_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_product     (o_product),
        .o_inverse     (o_inverse),
        .o_has_inverse (o_has_inverse)
    );

endmodule

### sim/tb_gf256_multiply_inverse.sv
// Self-checking testbench for gf256_multiply_inverse: GF(2^8) product and inverse search
// under a programmable reduction polynomial, with an in-bench predictor and a result queue.
// Depends on gfmi_pkg and the RTL of gf256_multiply_inverse only.
module tb_gf256_multiply_inverse;

    import gfmi_pkg::*;

    localparam int unsigned        LIMIT_CYCLES    = 1_000_000;
    localparam int unsigned        DRAIN_CYCLES    = 300;
    localparam int unsigned        SEGMENT_ITEMS   = 75;
    localparam int unsigned        SEGMENTS        = 10;
    localparam int                 REG_MODULUS_IDX = int'(C_REG_MODULUS);
    localparam int                 REG_SPARE_IDX   = 1;
    localparam logic [C_POLY_W-1:0] AES_POLY       = 9'h11B;

    typedef struct packed {
        logic [C_ELEM_W-1:0] a;
        logic [C_ELEM_W-1:0] b;
    } t_gf_operands;

    typedef struct packed {
        logic [C_ELEM_W-1:0] product;
        logic [C_ELEM_W-1:0] inverse;
        logic                has_inverse;
    } t_gf_result;

    // DUT signals, all inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [C_ELEM_W-1:0]  i_operand_a   = '0;
    logic [C_ELEM_W-1:0]  i_operand_b   = '0;
    logic                 o_done;
    logic [C_ELEM_W-1:0]  o_product;
    logic [C_ELEM_W-1:0]  o_inverse;
    logic                 o_has_inverse;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [C_APB_AW-1:0]  paddr         = '0;
    logic [C_APB_DW-1:0]  pwdata        = '0;
    logic [C_APB_DW-1:0]  prdata;
    logic                 pready;

    // Bench state
    t_gf_operands         pending_operands[$];
    t_gf_result           expected_results[$];
    logic [C_POLY_W-1:0]  model_poly    = AES_POLY;
    int unsigned          idle_pct      = 0;
    int unsigned          fail_count    = 0;
    int unsigned          cycle_count   = 0;
    int unsigned          items_sent    = 0;
    int unsigned          results_seen  = 0;
    int unsigned          poly_count    = 0;

    gf256_multiply_inverse u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_done        (o_done),
        .o_product     (o_product),
        .o_inverse     (o_inverse),
        .o_has_inverse (o_has_inverse),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock: 8 time units
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Carry-less multiply then reduction by the polynomial's own degree
    function automatic logic [C_ELEM_W-1:0] field_mul(input logic [C_ELEM_W-1:0] x,
                                                      input logic [C_ELEM_W-1:0] y,
                                                      input logic [C_POLY_W-1:0] poly);
        logic [C_CLMUL_W-1:0] acc;
        int                   deg;
        acc = '0;
        deg = 0;
        for (int k = 0; k < int'(C_ELEM_W); k++) begin
            if (y[k]) begin
                acc ^= C_CLMUL_W'(x) << k;
            end
        end
        // zero polynomial: plain truncation
        if (poly == '0) begin
            return acc[C_ELEM_W-1:0];
        end
        for (int k = 0; k < int'(C_POLY_W); k++) begin
            if (poly[k]) begin
                deg = k;
            end
        end
        for (int bit_i = int'(C_CLMUL_W) - 1; bit_i >= deg; bit_i--) begin
            if (acc[bit_i]) begin
                acc ^= C_CLMUL_W'(poly) << (bit_i - deg);
            end
        end
        // constant polynomial: everything reduces to nothing
        if (deg == 0) begin
            acc = '0;
        end
        return acc[C_ELEM_W-1:0];
    endfunction

    // Expected result: product plus the highest candidate giving one
    function automatic t_gf_result predict_gf_result(input t_gf_operands ops,
                                                     input logic [C_POLY_W-1:0] poly);
        t_gf_result res;
        int         j;
        res.product     = field_mul(ops.a, ops.b, poly);
        res.inverse     = '0;
        res.has_inverse = 1'b0;
        j = 255;
        while (j >= 1 && !res.has_inverse) begin
            if (field_mul(ops.a, C_ELEM_W'(j), poly) == 8'd1) begin
                res.inverse     = C_ELEM_W'(j);
                res.has_inverse = 1'b1;
            end
            j--;
        end
        return res;
    endfunction

    // Operand with a bias towards the edges of the byte range
    function automatic logic [C_ELEM_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            3:       return 8'h80;
            default: return C_ELEM_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Driver: present queued operands, count a transfer on start & !busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_gf_result({i_operand_a, i_operand_b},
                                                             model_poly));
                items_sent++;
            end
            if (start && busy) begin
                // hold the current item until it is taken
            end else if (pending_operands.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_gf_operands ops;
                ops = pending_operands.pop_front();
                start       <= 1'b1;
                i_operand_a <= ops.a;
                i_operand_b <= ops.b;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each o_done pulse against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no transfer outstanding: product %0h inverse %0h flag %0b",
                       o_product, o_inverse, o_has_inverse);
                fail_count++;
            end else begin
                t_gf_result exp_res;
                exp_res = expected_results.pop_front();
                if (o_product !== exp_res.product) begin
                    $error("product: expected %0h, got %0h", exp_res.product, o_product);
                    fail_count++;
                end
                if (o_inverse !== exp_res.inverse) begin
                    $error("inverse: expected %0h, got %0h", exp_res.inverse, o_inverse);
                    fail_count++;
                end
                if (o_has_inverse !== exp_res.has_inverse) begin
                    $error("has_inverse: expected %0b, got %0b",
                           exp_res.has_inverse, o_has_inverse);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Block quiet: nothing queued, nothing in flight
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_operands.size() > 0 || start || expected_results.size() > 0 || busy) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input int idx, input logic [C_APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= C_APB_AW'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (idx == REG_MODULUS_IDX) begin
            model_poly = data[C_POLY_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_modulus_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= C_APB_AW'(4 * REG_MODULUS_IDX);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata[C_POLY_W-1:0] !== model_poly) begin
            $error("modulus_poly: expected %0h, got %0h", model_poly, prdata[C_POLY_W-1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program the polynomial with junk in the unused upper bits, then read it back
    task automatic set_modulus(input logic [C_POLY_W-1:0] poly);
        wait_idle();
        repeat (4) @(negedge i_clk);
        apb_write(REG_MODULUS_IDX, (C_APB_DW'($urandom()) << C_POLY_W) | C_APB_DW'(poly));
        check_modulus_readback();
        poly_count++;
    endtask

    task automatic queue_operands(input logic [C_ELEM_W-1:0] a, input logic [C_ELEM_W-1:0] b);
        pending_operands.push_back({a, b});
    endtask

    // Polynomial for each random segment: fixed corners and random draws
    function automatic logic [C_POLY_W-1:0] segment_poly(input int seg);
        case (seg)
            0:       return AES_POLY;
            1:       return 9'h1FF;
            3:       return 9'h100;
            4:       return 9'h11D;
            5:       return C_POLY_W'($urandom_range(0, 511));
            7:       return 9'h163;
            default: return C_POLY_W'($urandom_range(256, 511));
        endcase
    endfunction

    // Sequencer
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset polynomial: zero operand, extremes, the textbook pair
        idle_pct = 12;
        queue_operands(8'h00, 8'h00);
        queue_operands(8'h00, 8'hFF);
        queue_operands(8'hFF, 8'h00);
        queue_operands(8'h01, 8'h01);
        queue_operands(8'hFF, 8'hFF);
        queue_operands(8'h53, 8'hCA);
        queue_operands(8'h02, 8'h8D);
        queue_operands(8'h80, 8'h02);
        queue_operands(8'hAA, 8'h55);
        queue_operands(8'h55, 8'hAA);
        check_modulus_readback();

        // Write to the spare index must leave the polynomial alone
        wait_idle();
        apb_write(REG_SPARE_IDX, 32'hFFFF_FE00);
        check_modulus_readback();

        // Zero polynomial: truncated product
        set_modulus(9'h000);
        queue_operands(8'hFF, 8'hFF);
        queue_operands(8'h01, 8'h37);
        queue_operands(8'h81, 8'h03);

        // Constant one: everything reduces to zero
        set_modulus(9'h001);
        queue_operands(8'h01, 8'h01);
        queue_operands(8'hC3, 8'h7E);
        queue_operands(8'hFF, 8'hFF);

        // Low-degree polynomial x^3 + x + 1
        set_modulus(9'h00B);
        queue_operands(8'h01, 8'hFF);
        queue_operands(8'h05, 8'h06);
        queue_operands(8'hF0, 8'h0F);

        // Reducible x^8: odd operands have an inverse, even ones have none
        set_modulus(9'h100);
        queue_operands(8'h03, 8'hFF);
        queue_operands(8'h02, 8'h80);
        queue_operands(8'hFF, 8'h01);

        // Random segments: sender idles 12 percent, then 54, then never
        for (int seg = 0; seg < int'(SEGMENTS); seg++) begin
            set_modulus(segment_poly(seg));
            idle_pct = (seg < 4) ? 12 : (seg < 7) ? 54 : 0;
            for (int n = 0; n < int'(SEGMENT_ITEMS); n++) begin
                queue_operands(rand_operand(), rand_operand());
            end
        end

        // Drain, then allow the pipeline to go quiet
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() > 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end

        $display("Run covered %0d operand transfers and %0d results under %0d polynomial settings",
                 items_sent, results_seen, poly_count);
        $display("(zero, constant, low-degree, reducible and degree-8 moduli), in %0d cycles",
                 cycle_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gfmi_pkg.sv
rtl/gfmi_mul.sv
rtl/gfmi_datapath.sv
rtl/gfmi_ctrl.sv
rtl/gf256_multiply_inverse.sv
sim/tb_gf256_multiply_inverse.sv
